// File: rtl/direct_mapped_word_cache_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the direct-mapped word cache
// Clocked concurrent assertions, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_WORD_CACHE_CORE_ASSERT_SVH
`define DIRECT_MAPPED_WORD_CACHE_CORE_ASSERT_SVH

// Plain property check on the rising clock edge.
`define DMC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define DMC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared constants, types and codes of the direct-mapped word cache.
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

    localparam int ADDR_BITS   = 32;
    localparam int WORD_BITS   = 32;
    localparam int INDEX_BITS  = 6;
    localparam int OFFSET_BITS = 2;
    localparam int TAG_BITS    = ADDR_BITS - INDEX_BITS - OFFSET_BITS;
    localparam int LINES       = 1 << INDEX_BITS;

    // stream payload layout
    localparam int S_DATA_BITS = 3 * WORD_BITS;   // address, write_data, fill_word
    localparam int S_USER_BITS = 1;               // opcode
    localparam int M_DATA_BITS = 3 * WORD_BITS;   // read_data, hit_total, miss_total
    localparam int M_USER_BITS = 3;               // hit, memory_read, memory_write

    localparam int USER_HIT    = 0;
    localparam int USER_MREAD  = 1;
    localparam int USER_MWRITE = 2;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef logic [INDEX_BITS-1:0] index_t;
    typedef logic [TAG_BITS-1:0]   tag_t;
    typedef logic [WORD_BITS-1:0]  word_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // input transfer: latch access, start array read
        logic commit;    // lookup done and output register free
    } dp_cmd_t;

endpackage

`default_nettype wire

// File: rtl/dmc_ram.sv
// ----------------------------------------------------------------------------
// dmc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/dmc_ctrl.sv
// ----------------------------------------------------------------------------
// dmc_ctrl
// Access sequencer: accept, lookup/commit, output valid tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_ctrl (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    output dmc_pkg::dp_cmd_t cmd
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOOK
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = out_valid_reg;
    assign out_free    = !out_valid_reg || m_tready;
    assign cmd.capture = s_tvalid && s_tready;
    assign cmd.commit  = (state_reg == ST_LOOK) && out_free;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                // hold the lookup until the previous result has left
                if (cmd.commit)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dmc_datapath.sv
// ----------------------------------------------------------------------------
// dmc_datapath
// Tag and word arrays, valid bits, hit compare, counters, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire dmc_pkg::dp_cmd_t                   cmd,
    input  wire logic [dmc_pkg::S_DATA_BITS-1:0]    s_tdata,
    input  wire logic [dmc_pkg::S_USER_BITS-1:0]    s_tuser,
    output logic      [dmc_pkg::M_DATA_BITS-1:0]    m_tdata,
    output logic      [dmc_pkg::M_USER_BITS-1:0]    m_tuser
);

    localparam int WB = dmc_pkg::WORD_BITS;

    dmc_pkg::word_t  in_addr;
    dmc_pkg::index_t in_index;

    // latched access
    logic            op_reg;
    dmc_pkg::word_t  addr_reg;
    dmc_pkg::word_t  wdata_reg;
    dmc_pkg::word_t  fill_reg;
    dmc_pkg::index_t index_reg;
    dmc_pkg::tag_t   tag_cur;

    dmc_pkg::tag_t   tag_rd;
    dmc_pkg::word_t  word_rd;

    logic [dmc_pkg::LINES-1:0] valid_reg, valid_next;
    dmc_pkg::word_t  hits_reg, hits_next;
    dmc_pkg::word_t  misses_reg, misses_next;

    logic            is_write;
    logic            is_hit;
    logic            is_miss;
    logic            line_wr;
    dmc_pkg::word_t  line_wdata;

    dmc_pkg::word_t  rdata_reg;
    dmc_pkg::word_t  hit_total_reg;
    dmc_pkg::word_t  miss_total_reg;
    logic            hit_reg;
    logic            mread_reg;
    logic            mwrite_reg;

    assign in_addr  = s_tdata[WB-1:0];
    assign in_index = in_addr[dmc_pkg::OFFSET_BITS +: dmc_pkg::INDEX_BITS];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= s_tuser[0];
            addr_reg  <= in_addr;
            wdata_reg <= s_tdata[2*WB-1:WB];
            fill_reg  <= s_tdata[3*WB-1:2*WB];
        end
    end

    assign index_reg = addr_reg[dmc_pkg::OFFSET_BITS +: dmc_pkg::INDEX_BITS];
    assign tag_cur   = addr_reg[dmc_pkg::ADDR_BITS-1 -: dmc_pkg::TAG_BITS];

    assign is_write   = (op_reg == dmc_pkg::OP_WRITE);
    assign is_hit     = !is_write && valid_reg[index_reg] && (tag_rd == tag_cur);
    assign is_miss    = !is_write && !is_hit;
    assign line_wr    = cmd.commit && !is_hit;
    assign line_wdata = is_write ? wdata_reg : fill_reg;

    dmc_ram #(
        .WIDTH (dmc_pkg::TAG_BITS),
        .DEPTH (dmc_pkg::LINES)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (line_wr),
        .wr_addr (index_reg),
        .wr_data (tag_cur),
        .rd_en   (cmd.capture),
        .rd_addr (in_index),
        .rd_data (tag_rd)
    );

    dmc_ram #(
        .WIDTH (WB),
        .DEPTH (dmc_pkg::LINES)
    ) u_word_ram (
        .clk     (clk),
        .wr_en   (line_wr),
        .wr_addr (index_reg),
        .wr_data (line_wdata),
        .rd_en   (cmd.capture),
        .rd_addr (in_index),
        .rd_data (word_rd)
    );

    always_comb
    begin
        valid_next  = valid_reg;
        hits_next   = hits_reg;
        misses_next = misses_reg;
        if (line_wr)
        begin
            valid_next[index_reg] = 1'b1;
        end
        if (cmd.commit && is_hit)
        begin
            hits_next = hits_reg + 32'd1;
        end
        if (cmd.commit && is_miss)
        begin
            misses_next = misses_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rdata_reg      <= is_write ? '0 : (is_hit ? word_rd : fill_reg);
            hit_reg        <= is_hit;
            mread_reg      <= is_miss;
            mwrite_reg     <= is_write;
            hit_total_reg  <= hits_next;
            miss_total_reg <= misses_next;
        end
    end

    assign m_tdata = {miss_total_reg, hit_total_reg, rdata_reg};

    always_comb
    begin
        m_tuser                       = '0;
        m_tuser[dmc_pkg::USER_HIT]    = hit_reg;
        m_tuser[dmc_pkg::USER_MREAD]  = mread_reg;
        m_tuser[dmc_pkg::USER_MWRITE] = mwrite_reg;
    end

endmodule

`default_nettype wire

// File: rtl/direct_mapped_word_cache_core.sv
// ----------------------------------------------------------------------------
// direct_mapped_word_cache_core
// Direct-mapped write-through, write-allocate cache of one-word lines.
// ----------------------------------------------------------------------------
// In each access, the transfer in starts a registered read of
// the tag and word RAMs at the line index, and the lookup state then compares the
// tag, updates the line and counters and loads the output register. The
// output register lets the next access be taken while a result still waits;
// a lookup is held while the output register holds an untaken result. Valid bits are
// flip-flops cleared by reset, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module direct_mapped_word_cache_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // address[31:0], write_data[63:32], fill_word[95:64]
    input  wire logic [dmc_pkg::S_DATA_BITS-1:0] s_tdata,
    // opcode[0]
    input  wire logic [dmc_pkg::S_USER_BITS-1:0] s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // read_data[31:0], hit_total[63:32], miss_total[95:64]
    output logic      [dmc_pkg::M_DATA_BITS-1:0] m_tdata,
    // hit[0], memory_read[1], memory_write[2]
    output logic      [dmc_pkg::M_USER_BITS-1:0] m_tuser
);

    dmc_pkg::dp_cmd_t cmd;

    dmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    dmc_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

`default_nettype wire

// File: rtl/dmc_checker.sv
// ----------------------------------------------------------------------------
// dmc_checker
// Port-level checks of the word cache, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "direct_mapped_word_cache_core_assert.svh"

module dmc_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [dmc_pkg::M_DATA_BITS-1:0] m_tdata,
    input wire logic [dmc_pkg::M_USER_BITS-1:0] m_tuser
);

    logic in_xfer;
    logic wr_result;

    assign in_xfer   = s_tvalid && s_tready;
    assign wr_result = m_tvalid && m_tuser[dmc_pkg::USER_MWRITE];

    // every result is exactly one of hit, miss fill, write-through
    `DMC_ASSERT_IMP(a_one_kind, clk, rst_n, m_tvalid, $onehot(m_tuser), "result kind not one-hot")

    `DMC_ASSERT_IMP(a_write_zero, clk, rst_n, wr_result, m_tdata[dmc_pkg::WORD_BITS-1:0] == '0, "write result carries nonzero read data")

    // lookup cycle follows every accepted access
    `DMC_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_xfer, !s_tready, "ready during lookup")

    `DMC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind direct_mapped_word_cache_core dmc_checker u_dmc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
